// ===== rtl/ihds_pkg.sv =====
// shared types and constants for the image header dimension sniffer
// no dependencies

package ihds_pkg;

   typedef enum logic [1:0] {
      FMT_UNKNOWN = 2'd0,
      FMT_PNG     = 2'd1,
      FMT_JPEG    = 2'd2,
      FMT_GIF     = 2'd3
   } image_format_type;

   // signature bytes
   localparam logic [7:0] PNG_SIG0 = 8'h89;
   localparam logic [7:0] PNG_SIG1 = 8'h50;
   localparam logic [7:0] PNG_SIG2 = 8'h4E;
   localparam logic [7:0] PNG_SIG3 = 8'h47;
   localparam logic [7:0] JPEG_SIG0 = 8'hFF;
   localparam logic [7:0] JPEG_SIG1 = 8'hD8;
   localparam logic [7:0] GIF_SIG0 = 8'h47;
   localparam logic [7:0] GIF_SIG1 = 8'h49;
   localparam logic [7:0] GIF_SIG2 = 8'h46;

   // jpeg markers
   localparam logic [7:0] JPEG_LEAD = 8'hFF;
   localparam logic [7:0] SOF_FIRST = 8'hC0;
   localparam logic [7:0] SOF_LAST  = 8'hC3;

   // bit positions in the signature flags
   localparam int SIG_PNG  = 0;
   localparam int SIG_JPEG = 1;
   localparam int SIG_GIF  = 2;

   // bit positions in the decision flags
   localparam int DEC_FOUND  = 0;
   localparam int DEC_FAILED = 1;

   // byte counts
   localparam logic [4:0] POS_MAX         = 5'd31;
   localparam logic [4:0] MIN_KNOWN_BYTES = 5'd8;
   localparam logic [4:0] MIN_PNG_BYTES   = 5'd24;
   localparam logic [4:0] MIN_GIF_BYTES   = 5'd10;

endpackage

// ===== rtl/image_header_dimension_sniffer.sv =====
// image header dimension sniffer: finds format, width and height of png, jpeg, gif
// depends on ihds_pkg
//
// usage
//    req channel carries one file word per handshake: req_data_byte and
//    req_end_of_file, which marks the last word of the file
//    rsp channel carries one result per file: format, dims_valid, width, height
//    the parse state updates once per accepted word, so a word can be taken
//    every cycle while req_ready is high; sustained rate is one word per cycle
//    while results are taken; the result is registered from the last word and
//    sits in an output register until taken; a spare register behind it holds
//    one more result, so a stalled result does not hold up the next file
//    req_ready drops only while both registers hold results; it comes straight
//    from a register, with no path from rsp_ready
//    after the last word the parse state returns to its reset values, so the
//    next word starts a new file
//    reset clears the parse state and drops rsp_valid; it needs no clearing pass

module image_header_dimension_sniffer
   import ihds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_image_format,
   output logic        rsp_dims_valid,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height
);

   logic             accept;
   logic             rsp_take;
   logic             new_rsp;

   logic [4:0]       pos_ff, pos_in;
   image_format_type fmt_ff, fmt_in;
   logic [2:0]       sig_ff, sig_in;
   logic [3:0]       seg_idx_ff, seg_idx_in;
   logic [15:0]      skip_ff, skip_in;
   logic [15:0]      seg_len_ff, seg_len_in;
   logic             seg_sof_ff, seg_sof_in;
   logic [31:0]      width_ff, width_in;
   logic [31:0]      height_ff, height_in;
   logic [1:0]       decided_ff, decided_in;

   logic             rsp_valid_ff, rsp_valid_in;
   image_format_type rsp_fmt_ff, rsp_fmt_in;
   logic             rsp_dims_ff, rsp_dims_in;
   logic [31:0]      rsp_width_ff, rsp_width_in;
   logic [31:0]      rsp_height_ff, rsp_height_in;

   logic             spare_valid_ff, spare_valid_in;
   image_format_type spare_fmt_ff;
   logic             spare_dims_ff;
   logic [31:0]      spare_width_ff;
   logic [31:0]      spare_height_ff;

   assign req_ready = !spare_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign new_rsp   = accept && req_end_of_file;

   always_comb begin
      logic [7:0]       b;
      logic [15:0]      len;
      image_format_type fmt_out;
      logic             dims;
      b          = req_data_byte;
      len        = {seg_len_ff[15:8], req_data_byte};
      fmt_out    = FMT_UNKNOWN;
      dims       = 1'b0;
      pos_in     = pos_ff;
      fmt_in     = fmt_ff;
      sig_in     = sig_ff;
      seg_idx_in = seg_idx_ff;
      skip_in    = skip_ff;
      seg_len_in = seg_len_ff;
      seg_sof_in = seg_sof_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      decided_in = decided_ff;

      if (accept) begin
         // jpeg segment walk
         if (fmt_ff == FMT_JPEG && pos_ff >= 5'd2 && decided_ff == 2'b00) begin
            if (skip_ff != 16'd0) begin
               skip_in = skip_ff - 16'd1;
            end else begin
               unique case (seg_idx_ff)
                  4'd0: begin
                     if (b != JPEG_LEAD) decided_in[DEC_FAILED] = 1'b1;
                     else seg_idx_in = 4'd1;
                  end
                  4'd1: begin
                     seg_sof_in = (b >= SOF_FIRST) && (b <= SOF_LAST);
                     seg_idx_in = 4'd2;
                  end
                  4'd2: begin
                     seg_len_in = {b, 8'd0};
                     seg_idx_in = 4'd3;
                  end
                  4'd3: begin
                     seg_len_in = len;
                     if (seg_sof_ff) begin
                        seg_idx_in = 4'd4;
                     end else if (len < 16'd2) begin
                        decided_in[DEC_FAILED] = 1'b1;
                     end else begin
                        skip_in    = len - 16'd2;
                        seg_idx_in = 4'd0;
                     end
                  end
                  4'd4: seg_idx_in = 4'd5;
                  4'd5: begin
                     height_in  = {16'd0, b, 8'd0};
                     seg_idx_in = 4'd6;
                  end
                  4'd6: begin
                     height_in  = height_ff | {24'd0, b};
                     seg_idx_in = 4'd7;
                  end
                  4'd7: begin
                     width_in   = {16'd0, b, 8'd0};
                     seg_idx_in = 4'd8;
                  end
                  default: begin
                     width_in              = width_ff | {24'd0, b};
                     decided_in[DEC_FOUND] = 1'b1;
                  end
               endcase
            end
         end

         // fixed-offset fields
         if (fmt_ff == FMT_PNG) begin
            if (pos_ff >= 5'd16 && pos_ff <= 5'd19) width_in = {width_ff[23:0], b};
            else if (pos_ff >= 5'd20 && pos_ff <= 5'd23) height_in = {height_ff[23:0], b};
         end else if (fmt_ff == FMT_GIF) begin
            if (pos_ff == 5'd6) width_in = {24'd0, b};
            else if (pos_ff == 5'd7) width_in = width_ff | {16'd0, b, 8'd0};
            else if (pos_ff == 5'd8) height_in = {24'd0, b};
            else if (pos_ff == 5'd9) height_in = height_ff | {16'd0, b, 8'd0};
         end

         // signature match
         if (pos_ff == 5'd0) begin
            if (b != PNG_SIG0) sig_in[SIG_PNG] = 1'b0;
            if (b != JPEG_SIG0) sig_in[SIG_JPEG] = 1'b0;
            if (b != GIF_SIG0) sig_in[SIG_GIF] = 1'b0;
         end else if (pos_ff == 5'd1) begin
            if (b != PNG_SIG1) sig_in[SIG_PNG] = 1'b0;
            if (b != JPEG_SIG1) sig_in[SIG_JPEG] = 1'b0;
            if (b != GIF_SIG1) sig_in[SIG_GIF] = 1'b0;
         end else if (pos_ff == 5'd2) begin
            if (b != PNG_SIG2) sig_in[SIG_PNG] = 1'b0;
            if (b != GIF_SIG2) sig_in[SIG_GIF] = 1'b0;
         end else if (pos_ff == 5'd3) begin
            if (b != PNG_SIG3) sig_in[SIG_PNG] = 1'b0;
         end

         pos_in = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 5'd1;

         priority if (sig_in[SIG_PNG] && pos_in >= 5'd4) fmt_in = FMT_PNG;
         else if (sig_in[SIG_JPEG] && pos_in >= 5'd2) fmt_in = FMT_JPEG;
         else if (sig_in[SIG_GIF] && pos_in >= 5'd3) fmt_in = FMT_GIF;
         else fmt_in = FMT_UNKNOWN;

         if (req_end_of_file) begin
            fmt_out = (pos_in >= MIN_KNOWN_BYTES) ? fmt_in : FMT_UNKNOWN;
            unique case (fmt_out)
               FMT_PNG:     dims = pos_in >= MIN_PNG_BYTES;
               FMT_GIF:     dims = pos_in >= MIN_GIF_BYTES;
               FMT_JPEG:    dims = decided_in[DEC_FOUND];
               FMT_UNKNOWN: dims = 1'b0;
            endcase
         end
      end

      rsp_fmt_in    = fmt_out;
      rsp_dims_in   = dims;
      rsp_width_in  = dims ? width_in : 32'd0;
      rsp_height_in = dims ? height_in : 32'd0;

      // start over after the last word
      if (accept && req_end_of_file) begin
         pos_in     = 5'd0;
         fmt_in     = FMT_UNKNOWN;
         sig_in     = 3'b111;
         seg_idx_in = 4'd0;
         skip_in    = 16'd0;
         seg_len_in = 16'd0;
         seg_sof_in = 1'b0;
         width_in   = 32'd0;
         height_in  = 32'd0;
         decided_in = 2'b00;
      end

      if (!rsp_valid_ff || rsp_ready) rsp_valid_in = spare_valid_ff || new_rsp;
      else rsp_valid_in = 1'b1;

      if (spare_valid_ff) spare_valid_in = !rsp_take;
      else spare_valid_in = new_rsp && rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= 5'd0;
         fmt_ff         <= FMT_UNKNOWN;
         sig_ff         <= 3'b111;
         seg_idx_ff     <= 4'd0;
         skip_ff        <= 16'd0;
         seg_len_ff     <= 16'd0;
         seg_sof_ff     <= 1'b0;
         width_ff       <= 32'd0;
         height_ff      <= 32'd0;
         decided_ff     <= 2'b00;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         fmt_ff         <= fmt_in;
         sig_ff         <= sig_in;
         seg_idx_ff     <= seg_idx_in;
         skip_ff        <= skip_in;
         seg_len_ff     <= seg_len_in;
         seg_sof_ff     <= seg_sof_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         decided_ff     <= decided_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   // output register takes the spare first, else the new result
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         if (spare_valid_ff) begin
            rsp_fmt_ff    <= spare_fmt_ff;
            rsp_dims_ff   <= spare_dims_ff;
            rsp_width_ff  <= spare_width_ff;
            rsp_height_ff <= spare_height_ff;
         end else if (new_rsp) begin
            rsp_fmt_ff    <= rsp_fmt_in;
            rsp_dims_ff   <= rsp_dims_in;
            rsp_width_ff  <= rsp_width_in;
            rsp_height_ff <= rsp_height_in;
         end
      end
      if (new_rsp && rsp_valid_ff && !rsp_ready) begin
         spare_fmt_ff    <= rsp_fmt_in;
         spare_dims_ff   <= rsp_dims_in;
         spare_width_ff  <= rsp_width_in;
         spare_height_ff <= rsp_height_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_image_format = rsp_fmt_ff;
   assign rsp_dims_valid   = rsp_dims_ff;
   assign rsp_image_width  = rsp_width_ff;
   assign rsp_image_height = rsp_height_ff;

   a_eof_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_file |=> rsp_valid_ff && pos_ff == 5'd0 && sig_ff == 3'b111)
      else $error("last word did not produce a result or restart the parser");

   a_decided_exclusive: assert property (@(posedge clock) disable iff (reset)
      decided_ff != 2'b11)
      else $error("jpeg walk both found and failed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_dims_ff |-> rsp_width_ff == 32'd0 && rsp_height_ff == 32'd0)
      else $error("dimensions not zero on an invalid result");

   a_unknown_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fmt_ff == FMT_UNKNOWN |-> !rsp_dims_ff)
      else $error("unknown format reported valid dimensions");

endmodule

// ===== tb/tb_image_header_dimension_sniffer.sv =====
// testbench for image_header_dimension_sniffer: png, gif, jpeg and noise files are streamed
// one word at a time and each result is checked against a table entry or an in-bench parser
// depends on ihds_pkg and image_header_dimension_sniffer
`timescale 1ns / 100ps

module tb_image_header_dimension_sniffer
   import ihds_pkg::*;
;

   localparam int RANDOM_WORDS    = 900;
   localparam int RANDOM_FILES    = 48;
   localparam int WATCHDOG_CYCLES = 1000;

   typedef enum logic [2:0] {
      FILE_NOISE,
      FILE_PNG,
      FILE_GIF,
      FILE_JPEG,
      FILE_JPEG_BAD_LEAD
   } file_kind_type;

   typedef struct packed {
      image_format_type fmt;
      logic             dims_valid;
      logic [31:0]      width;
      logic [31:0]      height;
   } image_dims_type;

   // length 0 means the natural length of the kind
   typedef struct packed {
      file_kind_type  kind;
      logic [7:0]     length;
      logic [31:0]    width;
      logic [31:0]    height;
      logic [7:0]     marker;
      logic [15:0]    skip_len;
      logic           has_skip;
      logic           typed;
      image_dims_type want;
   } file_case_type;

   localparam image_dims_type NO_DIMS = '{FMT_UNKNOWN, 1'b0, 32'd0, 32'd0};
   localparam int DIRECTED_COUNT = 23;
   localparam file_case_type DIRECTED_FILES [DIRECTED_COUNT] = '{
      '{FILE_NOISE, 8'd1, 32'd0, 32'd0, 8'h00, 16'd0, 1'b0, 1'b1, NO_DIMS},
      '{FILE_PNG, 8'd7, 32'd1, 32'd1, 8'h00, 16'd0, 1'b0, 1'b1, NO_DIMS},
      '{FILE_NOISE, 8'd12, 32'd0, 32'd0, 8'h00, 16'd0, 1'b0, 1'b1, NO_DIMS},
      '{FILE_PNG, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_PNG, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
      '{FILE_PNG, 8'd0, 32'd0, 32'd0, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_PNG, 1'b1, 32'd0, 32'd0}},
      '{FILE_PNG, 8'd23, 32'h1234_5678, 32'h9ABC_DEF0, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_PNG, 1'b0, 32'd0, 32'd0}},
      '{FILE_PNG, 8'd8, 32'd5, 32'd5, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_PNG, 1'b0, 32'd0, 32'd0}},
      '{FILE_PNG, 8'd40, 32'h8000_0001, 32'h0001_0000, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_PNG, 1'b1, 32'h8000_0001, 32'h0001_0000}},
      '{FILE_GIF, 8'd0, 32'h0000_FFFF, 32'h0000_FFFF, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_GIF, 1'b1, 32'h0000_FFFF, 32'h0000_FFFF}},
      '{FILE_GIF, 8'd9, 32'h0000_1234, 32'h0000_5678, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_GIF, 1'b0, 32'd0, 32'd0}},
      '{FILE_GIF, 8'd7, 32'd3, 32'd3, 8'h00, 16'd0, 1'b0, 1'b1, NO_DIMS},
      '{FILE_GIF, 8'd20, 32'h0000_0001, 32'h0000_0100, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_GIF, 1'b1, 32'h0000_0001, 32'h0000_0100}},
      '{FILE_JPEG, 8'd0, 32'h0000_FFFF, 32'h0000_FFFF, SOF_FIRST, 16'd0, 1'b0, 1'b1,
        '{FMT_JPEG, 1'b1, 32'h0000_FFFF, 32'h0000_FFFF}},
      '{FILE_JPEG, 8'd0, 32'd0, 32'd0, 8'hC1, 16'd2, 1'b1, 1'b1,
        '{FMT_JPEG, 1'b1, 32'd0, 32'd0}},
      '{FILE_JPEG, 8'd0, 32'd640, 32'd480, 8'hC2, 16'd6, 1'b1, 1'b0, NO_DIMS},
      '{FILE_JPEG, 8'd40, 32'd1920, 32'd1080, SOF_LAST, 16'd17, 1'b1, 1'b0, NO_DIMS},
      '{FILE_JPEG, 8'd0, 32'd7, 32'd7, SOF_FIRST, 16'd0, 1'b1, 1'b1,
        '{FMT_JPEG, 1'b0, 32'd0, 32'd0}},
      '{FILE_JPEG, 8'd0, 32'd7, 32'd7, SOF_FIRST, 16'd1, 1'b1, 1'b1,
        '{FMT_JPEG, 1'b0, 32'd0, 32'd0}},
      '{FILE_JPEG_BAD_LEAD, 8'd12, 32'd0, 32'd0, 8'h00, 16'd0, 1'b0, 1'b1,
        '{FMT_JPEG, 1'b0, 32'd0, 32'd0}},
      '{FILE_JPEG, 8'd10, 32'd9, 32'd9, SOF_FIRST, 16'd0, 1'b0, 1'b1,
        '{FMT_JPEG, 1'b0, 32'd0, 32'd0}},
      '{FILE_JPEG, 8'd30, 32'd11, 32'd12, 8'hC4, 16'd0, 1'b0, 1'b0, NO_DIMS},
      '{FILE_JPEG, 8'd24, 32'd13, 32'd14, 8'hBF, 16'd3, 1'b1, 1'b0, NO_DIMS},
      '{FILE_NOISE, 8'd35, 32'd0, 32'd0, 8'h00, 16'd0, 1'b0, 1'b0, NO_DIMS}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_image_format;
   logic        rsp_dims_valid;
   logic [31:0] rsp_image_width;
   logic [31:0] rsp_image_height;

   // parser state
   logic [4:0]       byte_count;
   image_format_type guess;
   logic [2:0]       sig_alive;
   logic [3:0]       seg_index;
   logic [15:0]      skip_left;
   logic [15:0]      seg_length;
   logic             seg_is_sof;
   logic [31:0]      width_acc;
   logic [31:0]      height_acc;
   logic             frame_found;
   logic             walk_failed;

   image_dims_type expected_dims [$];
   logic [7:0]     file_bytes [$];

   logic           word_typed = 1'b0;
   image_dims_type word_want = NO_DIMS;
   logic           word_quiet = 1'b0;
   int             rsp_hold = 3;
   int             idle_cycles = 0;
   int             mismatches = 0;
   int             results_seen = 0;
   int             results_with_dims = 0;
   int             words_sent = 0;
   int             files_sent = 0;

   image_header_dimension_sniffer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_image_format (rsp_image_format),
      .rsp_dims_valid   (rsp_dims_valid),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_parser();
      byte_count  = 5'd0;
      guess       = FMT_UNKNOWN;
      sig_alive   = 3'b111;
      seg_index   = 4'd0;
      skip_left   = 16'd0;
      seg_length  = 16'd0;
      seg_is_sof  = 1'b0;
      width_acc   = 32'd0;
      height_acc  = 32'd0;
      frame_found = 1'b0;
      walk_failed = 1'b0;
   endtask

   task automatic parse_word(input logic [7:0] b, input logic eof, output logic done,
                             output image_dims_type dims);
      logic [4:0] p;
      logic [4:0] seen;
      p = byte_count;
      done = 1'b0;
      dims = NO_DIMS;

      if (guess == FMT_JPEG && p >= 5'd2 && !frame_found && !walk_failed) begin
         if (skip_left != 16'd0) begin
            skip_left = skip_left - 16'd1;
         end else begin
            case (seg_index)
               4'd0: begin
                  if (b != JPEG_LEAD) walk_failed = 1'b1;
                  else seg_index = 4'd1;
               end
               4'd1: begin
                  seg_is_sof = (b >= SOF_FIRST && b <= SOF_LAST);
                  seg_index = 4'd2;
               end
               4'd2: begin
                  seg_length = {b, 8'h00};
                  seg_index = 4'd3;
               end
               4'd3: begin
                  seg_length = {seg_length[15:8], b};
                  if (seg_is_sof) begin
                     seg_index = 4'd4;
                  end else if (seg_length < 16'd2) begin
                     walk_failed = 1'b1;
                  end else begin
                     skip_left = seg_length - 16'd2;
                     seg_index = 4'd0;
                  end
               end
               4'd4: seg_index = 4'd5;
               4'd5: begin
                  height_acc = {16'd0, b, 8'd0};
                  seg_index = 4'd6;
               end
               4'd6: begin
                  height_acc = height_acc | {24'd0, b};
                  seg_index = 4'd7;
               end
               4'd7: begin
                  width_acc = {16'd0, b, 8'd0};
                  seg_index = 4'd8;
               end
               default: begin
                  width_acc = width_acc | {24'd0, b};
                  frame_found = 1'b1;
               end
            endcase
         end
      end

      if (guess == FMT_PNG) begin
         if (p >= 5'd16 && p <= 5'd19) width_acc = {width_acc[23:0], b};
         else if (p >= 5'd20 && p <= 5'd23) height_acc = {height_acc[23:0], b};
      end else if (guess == FMT_GIF) begin
         case (p)
            5'd6: width_acc = {24'd0, b};
            5'd7: width_acc = width_acc | {16'd0, b, 8'd0};
            5'd8: height_acc = {24'd0, b};
            5'd9: height_acc = height_acc | {16'd0, b, 8'd0};
            default: ;
         endcase
      end

      case (p)
         5'd0: begin
            if (b != PNG_SIG0) sig_alive[SIG_PNG] = 1'b0;
            if (b != JPEG_SIG0) sig_alive[SIG_JPEG] = 1'b0;
            if (b != GIF_SIG0) sig_alive[SIG_GIF] = 1'b0;
         end
         5'd1: begin
            if (b != PNG_SIG1) sig_alive[SIG_PNG] = 1'b0;
            if (b != JPEG_SIG1) sig_alive[SIG_JPEG] = 1'b0;
            if (b != GIF_SIG1) sig_alive[SIG_GIF] = 1'b0;
         end
         5'd2: begin
            if (b != PNG_SIG2) sig_alive[SIG_PNG] = 1'b0;
            if (b != GIF_SIG2) sig_alive[SIG_GIF] = 1'b0;
         end
         5'd3: begin
            if (b != PNG_SIG3) sig_alive[SIG_PNG] = 1'b0;
         end
         default: ;
      endcase

      byte_count = (p < POS_MAX) ? p + 5'd1 : POS_MAX;
      seen = byte_count;
      if (sig_alive[SIG_PNG] && seen >= 5'd4) guess = FMT_PNG;
      else if (sig_alive[SIG_JPEG] && seen >= 5'd2) guess = FMT_JPEG;
      else if (sig_alive[SIG_GIF] && seen >= 5'd3) guess = FMT_GIF;
      else guess = FMT_UNKNOWN;

      if (eof) begin
         done = 1'b1;
         dims.fmt = (seen >= MIN_KNOWN_BYTES) ? guess : FMT_UNKNOWN;
         case (dims.fmt)
            FMT_PNG: dims.dims_valid = (seen >= MIN_PNG_BYTES);
            FMT_GIF: dims.dims_valid = (seen >= MIN_GIF_BYTES);
            FMT_JPEG: dims.dims_valid = frame_found;
            default: dims.dims_valid = 1'b0;
         endcase
         if (dims.dims_valid) begin
            dims.width = width_acc;
            dims.height = height_acc;
         end
         clear_parser();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // one word per accepted handshake on either side
   always @(posedge clock) begin
      image_dims_type due;
      image_dims_type predicted;
      logic           produced;
      if (reset) begin
         clear_parser();
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dims.size() == 0) begin
               $error("result with no file pending: image_format %0d", rsp_image_format);
               mismatches++;
            end else begin
               due = expected_dims.pop_front();
               check_field("image_format", 32'(due.fmt), 32'(rsp_image_format));
               check_field("dims_valid", 32'(due.dims_valid), 32'(rsp_dims_valid));
               check_field("image_width", due.width, rsp_image_width);
               check_field("image_height", due.height, rsp_image_height);
            end
            results_seen++;
            if (rsp_dims_valid) results_with_dims++;
            rsp_hold = word_quiet ? 0 : $urandom_range(0, 7);
         end
         if (req_valid && req_ready) begin
            parse_word(req_data_byte, req_end_of_file, produced, predicted);
            if (produced) expected_dims.push_back(word_typed ? word_want : predicted);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_CYCLES);
            $display("image_header_dimension_sniffer: mismatch");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic build_file(input file_case_type c);
      int body;
      file_bytes.delete();
      case (c.kind)
         FILE_PNG: begin
            file_bytes = '{PNG_SIG0, PNG_SIG1, PNG_SIG2, PNG_SIG3, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
                           8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52};
            for (int i = 3; i >= 0; i--) file_bytes.push_back(c.width[8*i +: 8]);
            for (int i = 3; i >= 0; i--) file_bytes.push_back(c.height[8*i +: 8]);
         end
         FILE_GIF: begin
            file_bytes = '{GIF_SIG0, GIF_SIG1, GIF_SIG2, 8'h38, 8'h39, 8'h61,
                           c.width[7:0], c.width[15:8], c.height[7:0], c.height[15:8]};
         end
         FILE_JPEG: begin
            file_bytes = '{JPEG_SIG0, JPEG_SIG1};
            if (c.has_skip) begin
               file_bytes.push_back(JPEG_LEAD);
               file_bytes.push_back(8'($urandom_range(8'hC4, 8'hFE)));
               file_bytes.push_back(c.skip_len[15:8]);
               file_bytes.push_back(c.skip_len[7:0]);
               body = (c.skip_len > 16'd2) ? int'(c.skip_len) - 2 : 0;
               repeat (body) file_bytes.push_back(8'($urandom));
            end
            file_bytes.push_back(JPEG_LEAD);
            file_bytes.push_back(c.marker);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'h11);
            file_bytes.push_back(8'h08);
            file_bytes.push_back(c.height[15:8]);
            file_bytes.push_back(c.height[7:0]);
            file_bytes.push_back(c.width[15:8]);
            file_bytes.push_back(c.width[7:0]);
         end
         FILE_JPEG_BAD_LEAD: file_bytes = '{JPEG_SIG0, JPEG_SIG1, c.marker};
         default: file_bytes.push_back(8'($urandom_range(0, 8'h46)));
      endcase
      if (c.length != 8'd0) begin
         while (file_bytes.size() > c.length) void'(file_bytes.pop_back());
         while (file_bytes.size() < c.length) file_bytes.push_back(8'($urandom));
      end
   endtask

   task automatic send_word(input logic [7:0] b, input logic eof, input file_case_type c,
                            input logic quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_file <= eof;
      word_typed      <= c.typed;
      word_want       <= c.want;
      word_quiet      <= quiet;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_file(input file_case_type c, input logic quiet);
      int n;
      n = file_bytes.size();
      for (int i = 0; i < n; i++) send_word(file_bytes[i], i == n - 1, c, quiet);
      files_sent++;
   endtask

   initial begin
      file_case_type c;
      int            pick;
      int            spot;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         c = DIRECTED_FILES[i];
         build_file(c);
         send_file(c, $urandom_range(0, 3) == 0);
      end

      while (words_sent < RANDOM_WORDS || files_sent < RANDOM_FILES) begin
         c = '0;
         pick = $urandom_range(0, 19);
         if (pick < 6) c.kind = FILE_JPEG;
         else if (pick < 11) c.kind = FILE_PNG;
         else if (pick < 15) c.kind = FILE_GIF;
         else if (pick < 17) c.kind = FILE_JPEG_BAD_LEAD;
         else c.kind = FILE_NOISE;
         c.width  = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
         c.height = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
         if (c.kind == FILE_JPEG_BAD_LEAD) c.marker = 8'($urandom_range(0, 8'hFE));
         else if ($urandom_range(0, 7) == 0) c.marker = 8'($urandom);
         else c.marker = 8'($urandom_range(SOF_FIRST, SOF_LAST));
         c.has_skip = 1'($urandom_range(0, 1));
         c.skip_len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 300))
                                                  : 16'($urandom_range(0, 12));
         pick = $urandom_range(0, 9);
         if (c.kind == FILE_NOISE) c.length = 8'($urandom_range(1, 40));
         else if (pick < 6) c.length = 8'd0;
         else if (pick < 8) c.length = 8'($urandom_range(1, 23));
         else c.length = 8'($urandom_range(24, 40));
         build_file(c);
         if ($urandom_range(0, 9) == 0) begin
            spot = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
         end
         send_file(c, $urandom_range(0, 3) == 0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_dims.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d files in %0d words (png, gif, jpeg, truncated, corrupt, noise)",
               files_sent, words_sent);
      $display("%0d results checked, %0d of them with dimensions",
               results_seen, results_with_dims);
      if (mismatches == 0) begin
         $display("image_header_dimension_sniffer: match");
      end else begin
         $display("image_header_dimension_sniffer: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ihds_pkg.sv
rtl/image_header_dimension_sniffer.sv
tb/tb_image_header_dimension_sniffer.sv
